FILE: rtl/sis_pkg.sv
`default_nettype none

package sis_pkg;

  // Field and register widths
  localparam int unsigned LIMIT_W    = 18;
  localparam int unsigned ROUND_W    = 16;
  localparam int unsigned IVL_W      = 8;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] RST_IR_LIMIT     = 18'd100000;
  localparam logic [LIMIT_W-1:0] RST_BOTTOM_LIMIT = 18'd100000;
  localparam logic [LIMIT_W-1:0] RST_TOP_LIMIT    = 18'd200000;
  localparam logic [IVL_W-1:0]   RST_INTERVAL     = 8'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IR_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 2'd3;

  // Homing unit status
  localparam logic [1:0] HS_DONE   = 2'd1;
  localparam logic [1:0] HS_FAILED = 2'd2;

  // Scanner status
  localparam logic [1:0] SS_DONE    = 2'd1;
  localparam logic [1:0] SS_CAPTURE = 2'd2;
  localparam logic [1:0] SS_LIMIT   = 2'd3;

  // Sequencer mode, one-hot
  typedef enum logic [12:0] {
    MODE_IDLE     = 13'h0001,
    MODE_HOME_X   = 13'h0002,
    MODE_HOME_Y   = 13'h0004,
    MODE_HOME_CNV = 13'h0008,
    MODE_CHECK    = 13'h0010,
    MODE_FEED     = 13'h0020,
    MODE_IMAGE    = 13'h0040,
    MODE_REHOME_X = 13'h0080,
    MODE_REHOME_Y = 13'h0100,
    MODE_BOTTOM   = 13'h0200,
    MODE_TOP      = 13'h0400,
    MODE_NO_SMPL  = 13'h0800,
    MODE_FAULT    = 13'h1000
  } mode_e;

  typedef enum logic [CODE_W-1:0] {
    CMD_NONE        = 4'd0,
    CMD_HOME_X      = 4'd1,
    CMD_HOME_Y      = 4'd2,
    CMD_HOME_CNV    = 4'd3,
    CMD_DOWN_IR     = 4'd4,
    CMD_DOWN_BOTTOM = 4'd5,
    CMD_STOP_UP     = 4'd6,
    CMD_STOP_SCAN   = 4'd7,
    CMD_STOP_ALL    = 4'd8
  } cmd_e;

  typedef enum logic [CODE_W-1:0] {
    EVT_NONE       = 4'd0,
    EVT_STOPPED    = 4'd1,
    EVT_HOMING     = 4'd2,
    EVT_HOMED      = 4'd3,
    EVT_NO_SAMPLE  = 4'd4,
    EVT_FEEDING    = 4'd5,
    EVT_IMAGING    = 4'd6,
    EVT_DONE       = 4'd7,
    EVT_SCHED      = 4'd8,
    EVT_LOST       = 4'd9,
    EVT_REHOMED    = 4'd10,
    EVT_AT_BOTTOM  = 4'd11,
    EVT_ROUND_DONE = 4'd12,
    EVT_FAULT      = 4'd13
  } evt_e;

  typedef enum logic [CODE_W-1:0] {
    FLT_NONE     = 4'd0,
    FLT_FAR      = 4'd1,
    FLT_HOME_X   = 4'd2,
    FLT_HOME_Y   = 4'd3,
    FLT_HOME_CNV = 4'd4,
    FLT_JAM      = 4'd5,
    FLT_CAPTURE  = 4'd6,
    FLT_LIMIT    = 4'd7,
    FLT_BOTTOM   = 4'd8,
    FLT_TOP      = 4'd9
  } fault_e;

  typedef struct packed {
    logic       start_on;
    logic       x_home_hit;
    logic       y_home_hit;
    logic       x_far_hit;
    logic       y_far_hit;
    logic       bottom_hit;
    logic       top_hit;
    logic       sample_seen;
    logic       ir_seen;
    logic [1:0] homing_status;
    logic [1:0] scan_status;
    logic       conveyor_moving;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  mode;
    logic [CODE_W-1:0]  command;
    logic [LIMIT_W-1:0] move_limit;
    logic               abort_scan;
    logic               drivers_enabled;
    logic [CODE_W-1:0]  event_res;
    logic [CODE_W-1:0]  fault_reason;
    logic [ROUND_W-1:0] round_count;
  } out_item_t;

  typedef struct packed {
    mode_e              mode;
    logic [ROUND_W-1:0] rounds;
    logic [IVL_W-1:0]   countdown;
    logic               enable;
  } state_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] ir_limit;
    logic [LIMIT_W-1:0] bottom_limit;
    logic [LIMIT_W-1:0] top_limit;
    logic [IVL_W-1:0]   interval;
  } cfg_t;

  // Numeric mode code as seen on the result
  function automatic logic [CODE_W-1:0] mode_code(input mode_e m);
    logic [CODE_W-1:0] c;
    unique case (m)
      MODE_IDLE:     c = 4'd0;
      MODE_HOME_X:   c = 4'd1;
      MODE_HOME_Y:   c = 4'd2;
      MODE_HOME_CNV: c = 4'd3;
      MODE_CHECK:    c = 4'd4;
      MODE_FEED:     c = 4'd5;
      MODE_IMAGE:    c = 4'd6;
      MODE_REHOME_X: c = 4'd7;
      MODE_REHOME_Y: c = 4'd8;
      MODE_BOTTOM:   c = 4'd9;
      MODE_TOP:      c = 4'd10;
      MODE_NO_SMPL:  c = 4'd11;
      MODE_FAULT:    c = 4'd12;
      default:       c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sis_if.sv
`default_nettype none

// Tick channel into the sequencer
interface sis_in_if;
  import sis_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel out of the sequencer
interface sis_out_if;
  import sis_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sample_imaging_sequencer.sv
// Path: an accepted tick waits in the input register until the result register, free or
//   being drained, is loaded with the step logic's output for it.
// Throughput: one tick per clock unless out_o.ready holds results back; the result
//   and input registers let a new tick in while a finished result waits to be taken.
// Reset (rst_ni low, asynchronous): mode idle, round count zero, rehome countdown 10,
//   drivers enabled, configuration registers at their documented defaults.
`default_nettype none

module sample_imaging_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sis_in_if.sink                             in_i,
  sis_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sis_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sis_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sis_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t res_q;
  state_t    st_q;
  state_t    st_nxt;
  out_item_t res_nxt;
  cfg_t      cfg_q;
  logic      out_load;
  logic      in_take;

  // Result register takes the pending tick when free or being drained
  assign out_load = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_take = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  sis_step u_step (
    .item_i (s1_q),
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  // Handshake valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_i.data;
    end
    if (out_load) begin
      res_q <= res_nxt;
    end
  end

  // Sequencer state, advanced once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode      <= MODE_IDLE;
      st_q.rounds    <= '0;
      st_q.countdown <= RST_INTERVAL;
      st_q.enable    <= 1'b1;
    end else if (out_load) begin
      st_q <= st_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ir_limit     <= RST_IR_LIMIT;
      cfg_q.bottom_limit <= RST_BOTTOM_LIMIT;
      cfg_q.top_limit    <= RST_TOP_LIMIT;
      cfg_q.interval     <= RST_INTERVAL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IR_LIMIT:     cfg_q.ir_limit     <= cfg_data_i[LIMIT_W-1:0];
        CFG_BOTTOM_LIMIT: cfg_q.bottom_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_TOP_LIMIT:    cfg_q.top_limit    <= cfg_data_i[LIMIT_W-1:0];
        CFG_INTERVAL:     cfg_q.interval     <= cfg_data_i[IVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q.mode))
    else $error("mode register not one-hot");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(st_q))
    else $error("state changed without a processed item");

  a_pending_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_load |=> s1_valid_q && $stable(s1_q))
    else $error("pending item lost or altered");

  a_fault_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (res_nxt.fault_reason != FLT_NONE) |=> !st_q.enable)
    else $error("fault entry left drivers enabled");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> res_q.round_count == st_q.rounds
                 && res_q.drivers_enabled == st_q.enable)
    else $error("result disagrees with stored state");

endmodule

`default_nettype wire

FILE: rtl/sis_step.sv
`default_nettype none

// Next-state and result logic for one tick
module sis_step (
  input  sis_pkg::in_item_t  item_i,
  input  sis_pkg::state_t    st_i,
  input  sis_pkg::cfg_t      cfg_i,
  output sis_pkg::state_t    st_o,
  output sis_pkg::out_item_t res_o
);
  import sis_pkg::*;

  cmd_e               cmd;
  evt_e               evt;
  fault_e             rsn;
  logic [LIMIT_W-1:0] lim;
  logic               abort;
  logic               flt_go;
  fault_e             flt_code;
  logic               sched;
  logic               lost;
  state_t             nxt;

  always_comb begin
    cmd      = CMD_NONE;
    evt      = EVT_NONE;
    rsn      = FLT_NONE;
    lim      = '0;
    abort    = 1'b0;
    flt_go   = 1'b0;
    flt_code = FLT_NONE;
    sched    = (st_i.countdown <= IVL_W'(1));
    lost     = !item_i.x_home_hit || !item_i.y_home_hit;
    nxt      = st_i;

    if (!item_i.start_on) begin
      // stop switch: halt and go idle
      if (st_i.mode != MODE_IDLE) begin
        cmd           = CMD_STOP_ALL;
        evt           = EVT_STOPPED;
        nxt.enable    = 1'b1;
        nxt.mode      = MODE_IDLE;
        nxt.rounds    = '0;
        nxt.countdown = cfg_i.interval;
      end
    end else begin
      unique case (st_i.mode)
        MODE_IDLE: begin
          if (item_i.x_far_hit || item_i.y_far_hit) begin
            flt_go   = 1'b1;
            flt_code = FLT_FAR;
          end else begin
            cmd      = CMD_HOME_X;
            nxt.mode = MODE_HOME_X;
            evt      = EVT_HOMING;
          end
        end
        MODE_HOME_X, MODE_REHOME_X: begin
          if (item_i.homing_status == HS_FAILED) begin
            flt_go   = 1'b1;
            flt_code = FLT_HOME_X;
          end else if (item_i.homing_status == HS_DONE) begin
            cmd      = CMD_HOME_Y;
            nxt.mode = (st_i.mode == MODE_HOME_X) ? MODE_HOME_Y : MODE_REHOME_Y;
          end
        end
        MODE_HOME_Y: begin
          if (item_i.homing_status == HS_FAILED) begin
            flt_go   = 1'b1;
            flt_code = FLT_HOME_Y;
          end else if (item_i.homing_status == HS_DONE) begin
            cmd      = CMD_HOME_CNV;
            nxt.mode = MODE_HOME_CNV;
            evt      = EVT_HOMED;
          end
        end
        MODE_HOME_CNV: begin
          if (item_i.homing_status == HS_FAILED) begin
            flt_go   = 1'b1;
            flt_code = FLT_HOME_CNV;
          end else if (item_i.homing_status == HS_DONE) begin
            nxt.rounds    = '0;
            nxt.countdown = cfg_i.interval;
            nxt.mode      = MODE_CHECK;
          end
        end
        MODE_CHECK: begin
          if (!item_i.sample_seen) begin
            nxt.mode = MODE_NO_SMPL;
            evt      = EVT_NO_SAMPLE;
          end else begin
            cmd      = CMD_DOWN_IR;
            lim      = cfg_i.ir_limit;
            nxt.mode = MODE_FEED;
            evt      = EVT_FEEDING;
          end
        end
        MODE_FEED: begin
          if (item_i.ir_seen) begin
            cmd      = CMD_STOP_SCAN;
            nxt.mode = MODE_IMAGE;
            evt      = EVT_IMAGING;
          end else if (!item_i.conveyor_moving) begin
            flt_go   = 1'b1;
            flt_code = FLT_JAM;
          end
        end
        MODE_IMAGE: begin
          abort = item_i.x_home_hit || item_i.y_home_hit ||
                  item_i.x_far_hit || item_i.y_far_hit;
          if (item_i.scan_status == SS_CAPTURE) begin
            flt_go   = 1'b1;
            flt_code = FLT_CAPTURE;
          end else if (item_i.scan_status == SS_LIMIT) begin
            flt_go   = 1'b1;
            flt_code = FLT_LIMIT;
          end else if (item_i.scan_status == SS_DONE) begin
            // round finished: count it and decide on rehoming
            nxt.rounds    = st_i.rounds + ROUND_W'(1);
            nxt.countdown = sched ? cfg_i.interval : st_i.countdown - IVL_W'(1);
            if (sched) begin
              cmd      = CMD_HOME_X;
              nxt.mode = MODE_REHOME_X;
              evt      = EVT_SCHED;
            end else if (lost) begin
              cmd      = CMD_HOME_X;
              nxt.mode = MODE_REHOME_X;
              evt      = EVT_LOST;
            end else begin
              cmd      = CMD_DOWN_BOTTOM;
              lim      = cfg_i.bottom_limit;
              nxt.mode = MODE_BOTTOM;
              evt      = EVT_DONE;
            end
          end
        end
        MODE_REHOME_Y: begin
          if (item_i.homing_status == HS_FAILED) begin
            flt_go   = 1'b1;
            flt_code = FLT_HOME_Y;
          end else if (item_i.homing_status == HS_DONE) begin
            cmd      = CMD_DOWN_BOTTOM;
            lim      = cfg_i.bottom_limit;
            nxt.mode = MODE_BOTTOM;
            evt      = EVT_REHOMED;
          end
        end
        MODE_BOTTOM: begin
          if (item_i.bottom_hit) begin
            cmd      = CMD_STOP_UP;
            lim      = cfg_i.top_limit;
            nxt.mode = MODE_TOP;
            evt      = EVT_AT_BOTTOM;
          end else if (!item_i.conveyor_moving) begin
            flt_go   = 1'b1;
            flt_code = FLT_BOTTOM;
          end
        end
        MODE_TOP: begin
          if (item_i.top_hit) begin
            cmd      = CMD_STOP_ALL;
            nxt.mode = MODE_CHECK;
            evt      = EVT_ROUND_DONE;
          end else if (!item_i.conveyor_moving) begin
            flt_go   = 1'b1;
            flt_code = FLT_TOP;
          end
        end
        // no sample and fault hold until the stop switch
        MODE_NO_SMPL, MODE_FAULT: begin
        end
        default: begin
        end
      endcase
    end

    // fault entry overrides the move
    if (flt_go) begin
      cmd        = CMD_STOP_ALL;
      lim        = '0;
      nxt.enable = 1'b0;
      nxt.mode   = MODE_FAULT;
      evt        = EVT_FAULT;
      rsn        = flt_code;
    end
  end

  assign st_o = nxt;

  assign res_o.mode            = mode_code(nxt.mode);
  assign res_o.command         = cmd;
  assign res_o.move_limit      = lim;
  assign res_o.abort_scan      = abort;
  assign res_o.drivers_enabled = nxt.enable;
  assign res_o.event_res       = evt;
  assign res_o.fault_reason    = rsn;
  assign res_o.round_count     = nxt.rounds;

endmodule

`default_nettype wire

FILE: dv/sample_imaging_sequencer_tb.sv
`default_nettype none

module sample_imaging_sequencer_tb;
  import sis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned ITEMS_PHASE  = 240;
  localparam int unsigned IDLE_PCT     = 31;
  localparam int unsigned TAIL_CYCLES  = 8;

  // Status codes the package leaves unnamed
  localparam logic [1:0] HS_BUSY   = 2'd0;
  localparam logic [1:0] HS_SPARE  = 2'd3;
  localparam logic [1:0] SS_BUSY   = 2'd0;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam logic [IVL_W-1:0]   IVL_MAX   = 8'd255;

  // Mode as it appears on the result
  typedef enum logic [CODE_W-1:0] {
    ST_IDLE, ST_HOME_X, ST_HOME_Y, ST_HOME_CNV, ST_CHECK, ST_FEED, ST_IMAGE,
    ST_REHOME_X, ST_REHOME_Y, ST_BOTTOM, ST_TOP, ST_NO_SMPL, ST_FAULT
  } station_mode_e;

  // Scoreboard: predicts each tick's result and checks the DUT against it
  class station_scoreboard;
    logic [LIMIT_W-1:0] ir_limit, bottom_limit, top_limit;
    logic [IVL_W-1:0]   interval;
    station_mode_e      mode;
    logic [ROUND_W-1:0] rounds;
    logic [IVL_W-1:0]   countdown;
    logic               enable;
    out_item_t          res;
    out_item_t          expected_results[$];
    int unsigned        errors;

    function new();
      ir_limit     = RST_IR_LIMIT;
      bottom_limit = RST_BOTTOM_LIMIT;
      top_limit    = RST_TOP_LIMIT;
      interval     = RST_INTERVAL;
      mode         = ST_IDLE;
      rounds       = '0;
      countdown    = RST_INTERVAL;
      enable       = 1'b1;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_IR_LIMIT:     ir_limit     = val[LIMIT_W-1:0];
        CFG_BOTTOM_LIMIT: bottom_limit = val[LIMIT_W-1:0];
        CFG_TOP_LIMIT:    top_limit    = val[LIMIT_W-1:0];
        CFG_INTERVAL:     interval     = val[IVL_W-1:0];
        default: ;
      endcase
    endfunction

    function void enter_fault(fault_e why);
      res.command      = CMD_STOP_ALL;
      res.move_limit   = '0;
      res.event_res    = EVT_FAULT;
      res.fault_reason = why;
      enable           = 1'b0;
      mode             = ST_FAULT;
    endfunction

    function void start_move(cmd_e cmd, logic [LIMIT_W-1:0] lim, station_mode_e nxt, evt_e ev);
      res.command    = cmd;
      res.move_limit = lim;
      res.event_res  = ev;
      mode           = nxt;
    endfunction

    // Advance the predicted station by one accepted tick
    function void take_tick(in_item_t t);
      logic sched, lost;
      res = '0;
      if (!t.start_on) begin
        // stop switch: everything halts, back to idle
        if (mode != ST_IDLE) begin
          res.command   = CMD_STOP_ALL;
          res.event_res = EVT_STOPPED;
          enable        = 1'b1;
          mode          = ST_IDLE;
          rounds        = '0;
          countdown     = interval;
        end
      end else begin
        case (mode)
          ST_IDLE:
            if (t.x_far_hit || t.y_far_hit) enter_fault(FLT_FAR);
            else start_move(CMD_HOME_X, '0, ST_HOME_X, EVT_HOMING);
          ST_HOME_X, ST_REHOME_X:
            if (t.homing_status == HS_FAILED) enter_fault(FLT_HOME_X);
            else if (t.homing_status == HS_DONE)
              start_move(CMD_HOME_Y, '0, (mode == ST_HOME_X) ? ST_HOME_Y : ST_REHOME_Y,
                         EVT_NONE);
          ST_HOME_Y:
            if (t.homing_status == HS_FAILED) enter_fault(FLT_HOME_Y);
            else if (t.homing_status == HS_DONE)
              start_move(CMD_HOME_CNV, '0, ST_HOME_CNV, EVT_HOMED);
          ST_HOME_CNV:
            if (t.homing_status == HS_FAILED) enter_fault(FLT_HOME_CNV);
            else if (t.homing_status == HS_DONE) begin
              rounds    = '0;
              countdown = interval;
              mode      = ST_CHECK;
            end
          ST_CHECK:
            if (!t.sample_seen) begin
              mode          = ST_NO_SMPL;
              res.event_res = EVT_NO_SAMPLE;
            end else start_move(CMD_DOWN_IR, ir_limit, ST_FEED, EVT_FEEDING);
          ST_FEED:
            if (t.ir_seen) start_move(CMD_STOP_SCAN, '0, ST_IMAGE, EVT_IMAGING);
            else if (!t.conveyor_moving) enter_fault(FLT_JAM);
          ST_IMAGE: begin
            res.abort_scan = t.x_home_hit | t.y_home_hit | t.x_far_hit | t.y_far_hit;
            if (t.scan_status == SS_CAPTURE) enter_fault(FLT_CAPTURE);
            else if (t.scan_status == SS_LIMIT) enter_fault(FLT_LIMIT);
            else if (t.scan_status == SS_DONE) begin
              rounds = rounds + 1'b1;
              sched  = (countdown <= 1);
              if (sched) countdown = interval;
              else countdown = countdown - 1'b1;
              lost = !t.x_home_hit || !t.y_home_hit;
              if (sched) start_move(CMD_HOME_X, '0, ST_REHOME_X, EVT_SCHED);
              else if (lost) start_move(CMD_HOME_X, '0, ST_REHOME_X, EVT_LOST);
              else start_move(CMD_DOWN_BOTTOM, bottom_limit, ST_BOTTOM, EVT_DONE);
            end
          end
          ST_REHOME_Y:
            if (t.homing_status == HS_FAILED) enter_fault(FLT_HOME_Y);
            else if (t.homing_status == HS_DONE)
              start_move(CMD_DOWN_BOTTOM, bottom_limit, ST_BOTTOM, EVT_REHOMED);
          ST_BOTTOM:
            if (t.bottom_hit) start_move(CMD_STOP_UP, top_limit, ST_TOP, EVT_AT_BOTTOM);
            else if (!t.conveyor_moving) enter_fault(FLT_BOTTOM);
          ST_TOP:
            if (t.top_hit) start_move(CMD_STOP_ALL, '0, ST_CHECK, EVT_ROUND_DONE);
            else if (!t.conveyor_moving) enter_fault(FLT_TOP);
          default: ;  // no sample and fault hold until stopped
        endcase
      end
      res.mode            = mode;
      res.drivers_enabled = enable;
      res.round_count     = rounds;
      expected_results.push_back(res);
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result item arrived with none expected");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      check_field("mode", 32'(want.mode), 32'(got.mode));
      check_field("command", 32'(want.command), 32'(got.command));
      check_field("move_limit", 32'(want.move_limit), 32'(got.move_limit));
      check_field("abort_scan", 32'(want.abort_scan), 32'(got.abort_scan));
      check_field("drivers_enabled", 32'(want.drivers_enabled),
                  32'(got.drivers_enabled));
      check_field("event_res", 32'(want.event_res), 32'(got.event_res));
      check_field("fault_reason", 32'(want.fault_reason), 32'(got.fault_reason));
      check_field("round_count", 32'(want.round_count), 32'(got.round_count));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;
  int unsigned           cycles = 0;

  station_scoreboard board;

  sis_in_if  in_if ();
  sis_out_if out_if ();

  sample_imaging_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sample_imaging_sequencer_tb: done, errors");
      $finish;
    end
  end

  // Result side: random back-pressure, check every accepted item
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) board.check_result(out_if.data);
      out_if.ready <= calm || chance(100 - IDLE_PCT);
    end
  end

  // Present one tick, with optional idle cycles first; returns at its acceptance edge
  task automatic send_tick(input in_item_t t);
    while (!calm && chance(IDLE_PCT)) begin
      in_if.valid <= 1'b0;
      in_if.data  <= in_item_t'($urandom);
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (!in_if.ready);
    board.take_tick(t);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain;
    in_if.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One register write; the caller drops the write enable after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic program_phase(input int unsigned p);
    logic [LIMIT_W-1:0] ir_l, bot_l, top_l;
    logic [IVL_W-1:0]   ivl;
    if (p == 1) begin
      ir_l = LIMIT_W'(1); bot_l = LIMIT_W'(1); top_l = LIMIT_W'(1); ivl = IVL_W'(1);
    end else if (p == 2) begin
      ir_l = LIMIT_MAX; bot_l = LIMIT_MAX; top_l = LIMIT_MAX; ivl = IVL_MAX;
    end else begin
      ir_l  = LIMIT_W'($urandom_range(LIMIT_MAX, 1));
      bot_l = LIMIT_W'($urandom_range(LIMIT_MAX, 1));
      top_l = LIMIT_W'($urandom_range(LIMIT_MAX, 1));
      ivl   = chance(60) ? IVL_W'($urandom_range(3, 1)) : IVL_W'($urandom_range(IVL_MAX, 1));
    end
    write_reg(CFG_IR_LIMIT, CFG_DATA_W'(ir_l));
    write_reg(CFG_BOTTOM_LIMIT, CFG_DATA_W'(bot_l));
    write_reg(CFG_TOP_LIMIT, CFG_DATA_W'(top_l));
    write_reg(CFG_INTERVAL, CFG_DATA_W'(ivl));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] pick_homing();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return HS_DONE;
    if (r < 80) return HS_BUSY;
    if (r < 92) return HS_SPARE;
    return HS_FAILED;
  endfunction

  function automatic logic [1:0] pick_scan();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return SS_DONE;
    if (r < 85) return SS_BUSY;
    if (r < 93) return SS_CAPTURE;
    return SS_LIMIT;
  endfunction

  // Random tick shaped to move the station along from its current mode
  function automatic in_item_t shape_tick(input station_mode_e m);
    in_item_t t;
    t = in_item_t'($urandom);
    if (chance(10)) return t;
    t.start_on  = (m == ST_NO_SMPL || m == ST_FAULT) ? chance(70) : chance(97);
    t.x_far_hit = chance(4);
    t.y_far_hit = chance(4);
    case (m)
      ST_HOME_X, ST_HOME_Y, ST_HOME_CNV, ST_REHOME_X, ST_REHOME_Y:
        t.homing_status = pick_homing();
      ST_CHECK: t.sample_seen = chance(88);
      ST_FEED: begin
        t.ir_seen         = chance(45);
        t.conveyor_moving = chance(92);
      end
      ST_IMAGE: begin
        t.scan_status = pick_scan();
        t.x_home_hit  = chance(85);
        t.y_home_hit  = chance(85);
      end
      ST_BOTTOM: begin
        t.bottom_hit      = chance(40);
        t.conveyor_moving = chance(94);
      end
      ST_TOP: begin
        t.top_hit         = chance(40);
        t.conveyor_moving = chance(94);
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic in_item_t run_tick();
    in_item_t t;
    t          = '0;
    t.start_on = 1'b1;
    return t;
  endfunction

  // Hand-picked walk: faults, holding, stop switch, one full round, lost steps
  task automatic directed_walk;
    in_item_t t;
    t = '1; t.start_on = 1'b0; send_tick(t);          // stop switch in idle: nothing
    t = run_tick(); t.x_far_hit = 1'b1; send_tick(t); // far limit at start
    send_tick('0);
    send_tick(run_tick());                            // homing X begins
    t = run_tick(); t.homing_status = HS_SPARE; send_tick(t);
    t = run_tick(); t.homing_status = HS_DONE;
    repeat (3) send_tick(t);                          // X, Y, conveyor homed
    send_tick(run_tick());                            // no sample
    send_tick(run_tick());                            // held
    send_tick('0);
    send_tick(run_tick());
    t = run_tick(); t.homing_status = HS_DONE;
    repeat (3) send_tick(t);
    t = run_tick(); t.sample_seen = 1'b1; send_tick(t);
    t = run_tick(); t.ir_seen = 1'b1; t.conveyor_moving = 1'b1; send_tick(t);
    t = run_tick(); t.scan_status = SS_DONE; t.x_home_hit = 1'b1; t.y_home_hit = 1'b1;
    send_tick(t);
    t = run_tick(); t.bottom_hit = 1'b1; t.conveyor_moving = 1'b1; send_tick(t);
    t = run_tick(); t.top_hit = 1'b1; send_tick(t);   // round done
    t = run_tick(); t.sample_seen = 1'b1; send_tick(t);
    t = run_tick(); t.ir_seen = 1'b1; send_tick(t);
    t = run_tick(); t.scan_status = SS_DONE; t.y_home_hit = 1'b1; send_tick(t);  // lost steps
    t = run_tick(); t.homing_status = HS_FAILED; send_tick(t);
    send_tick('0);
  endtask

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    calm        = 1'b0;
    board       = new();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_walk();
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        repeat (2) @(posedge clk_i);
        program_phase(p);
      end
      calm = (p == 4);
      repeat (ITEMS_PHASE) send_tick(shape_tick(board.mode));
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("sample_imaging_sequencer_tb: done, clean");
    end else begin
      $display("sample_imaging_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sample_imaging_sequencer.f
rtl/sis_pkg.sv
rtl/sis_if.sv
rtl/sis_step.sv
rtl/sample_imaging_sequencer.sv
dv/sample_imaging_sequencer_tb.sv
